### hdl/art_pkg.sv
// Shared types and codes for the ack/retransmit tracker.
package art_pkg;

  // input item kinds (tuser)
  localparam logic [1:0] MODE_SEND = 2'd0;
  localparam logic [1:0] MODE_ACK  = 2'd1;
  localparam logic [1:0] MODE_SCAN = 2'd2;

  // result codes (tuser)
  localparam logic [2:0] EV_RECORDED    = 3'd0;
  localparam logic [2:0] EV_TABLE_FULL  = 3'd1;
  localparam logic [2:0] EV_ACK_MATCH   = 3'd2;
  localparam logic [2:0] EV_ACK_NOMATCH = 3'd3;
  localparam logic [2:0] EV_RESEND      = 3'd4;
  localparam logic [2:0] EV_RESEND_DROP = 3'd5;
  localparam logic [2:0] EV_SCAN_DONE   = 3'd6;

  // configuration register indexes
  localparam int unsigned     CFG_IDX_W          = 2;
  localparam int unsigned     CFG_DATA_W         = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESEND_TIMEOUT = 2'd1;

  // reset values
  localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd5;
  localparam logic [15:0] RESEND_TIMEOUT_RST = 16'd200;
  localparam logic [31:0] MIN_TRIP_RST       = 32'd100000;
  localparam logic [31:0] AVG_TRIP_RST       = 32'd50;
  localparam logic [31:0] MAX_TRIP_RST       = 32'd0;

  localparam logic [7:0]  RETRY_SAT = 8'hFF;

  // one table entry; key = {fragment_index, message_id}
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] sent_time;
    logic [7:0]  retries;
  } entry_t;

endpackage

### hdl/ack_retransmit_tracker.sv
// Top level: pending-ack table in a synchronous RAM, walked once per send, ack or scan item.
//
// Every item (send, ack or scan) walks the whole table through one RAM read
// port, one entry per cycle with read and check overlapped, except while a
// resend word waits for room on the result channel; a scan may emit one
// resend word per table entry along the way. An item of the unused kind is
// taken and gives nothing. The single read port of the table sets the pace
// of the walk. The result register lets the next item be taken while the
// last word still waits. Valid bits live in flops and clear at reset; the
// RAM needs no clearing pass. Statistics on every word are the values after
// the item's own update.
module ack_retransmit_tracker #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [art_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [art_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [63:0]                      in_tdata,  // message_id, fragment_index, now
  input  logic [1:0]                       in_tuser,  // mode
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_message_id, out_fragment_index, round_trip, min_, avg_, max_round_trip
  output logic [159:0]                     out_tdata,
  output logic [2:0]                       out_tuser, // event_res
  output logic                             out_tlast
);
  import art_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FINISH} state_t;

  // table RAM
  entry_t             mem [ENTRIES];
  entry_t             rdata_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  state_t             state_r, state_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [31:0]        now_r, now_nxt;
  logic [CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic               p_vld_r, p_vld_nxt;
  logic [IDX_W-1:0]   p_idx_r, p_idx_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [31:0]        trip_r, trip_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]        min_r, min_nxt;
  logic [31:0]        avg_r, avg_nxt;
  logic [31:0]        max_r, max_nxt;
  logic [7:0]         limit_r, limit_nxt;
  logic [15:0]        timeout_r, timeout_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [2:0]         out_ev_r, out_ev_nxt;
  logic [31:0]        out_key_r, out_key_nxt;
  logic [31:0]        out_rt_r, out_rt_nxt;
  logic               out_last_r, out_last_nxt;

  logic               out_free;
  logic               p_v;
  logic [31:0]        age;
  logic               key_hit;
  logic               scan_hit;
  logic [7:0]         ret_inc;
  logic               drop;
  logic               stall;
  logic [32:0]        avg_sum;
  logic [IDX_W-1:0]   send_slot;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {max_r, avg_r, min_r, out_rt_r, out_key_r};

  assign out_free = !out_vld_r || out_tready;
  assign p_v      = valid_r[p_idx_r];
  assign age      = now_r - rdata_r.sent_time;
  assign key_hit  = p_vld_r && p_v && (rdata_r.key == key_r);
  assign scan_hit = p_vld_r && (mode_r == MODE_SCAN) && p_v && (age > {16'd0, timeout_r});
  assign ret_inc  = (rdata_r.retries == RETRY_SAT) ? rdata_r.retries : rdata_r.retries + 8'd1;
  assign drop     = (ret_inc >= limit_r);
  assign stall    = scan_hit && !out_free;
  assign avg_sum  = {1'b0, avg_r} + {1'b0, trip_r};
  assign send_slot = found_r ? slot_r : free_idx_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    rd_cnt_nxt     = rd_cnt_r;
    p_vld_nxt      = p_vld_r;
    p_idx_nxt      = p_idx_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    trip_nxt       = trip_r;
    valid_nxt      = valid_r;
    min_nxt        = min_r;
    avg_nxt        = avg_r;
    max_nxt        = max_r;
    limit_nxt      = limit_r;
    timeout_nxt    = timeout_r;
    out_vld_nxt    = out_vld_r && !out_tready;
    out_ev_nxt     = out_ev_r;
    out_key_nxt    = out_key_r;
    out_rt_nxt     = out_rt_r;
    out_last_nxt   = out_last_r;
    rd_en          = 1'b0;
    rd_addr        = rd_cnt_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = p_idx_r;
    wr_data        = '{key: rdata_r.key, sent_time: now_r, retries: ret_inc};

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RETRY_LIMIT:    limit_nxt   = cfg_data[7:0];
        CFG_RESEND_TIMEOUT: timeout_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt       = in_tuser;
          key_nxt        = {in_tdata[31:16], in_tdata[15:0]};
          now_nxt        = in_tdata[63:32];
          rd_cnt_nxt     = '0;
          p_vld_nxt      = 1'b0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          if (in_tuser == MODE_SEND || in_tuser == MODE_ACK || in_tuser == MODE_SCAN) begin
            state_nxt = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (!stall) begin
          // read stage: issue the next entry
          if (rd_cnt_r != CNT_W'(ENTRIES)) begin
            rd_en      = 1'b1;
            p_vld_nxt  = 1'b1;
            p_idx_nxt  = rd_cnt_r[IDX_W-1:0];
            rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
          end else begin
            p_vld_nxt = 1'b0;
          end
          // check stage: entry last read from the RAM
          if (p_vld_r) begin
            case (mode_r) inside
              MODE_SEND, MODE_ACK: begin
                if (key_hit && !found_r) begin
                  found_nxt = 1'b1;
                  slot_nxt  = p_idx_r;
                  trip_nxt  = age;
                end
                if (!p_v && !free_found_r) begin
                  free_found_nxt = 1'b1;
                  free_idx_nxt   = p_idx_r;
                end
              end
              default: begin
                if (scan_hit) begin
                  wr_en        = 1'b1;
                  out_vld_nxt  = 1'b1;
                  out_ev_nxt   = drop ? EV_RESEND_DROP : EV_RESEND;
                  out_key_nxt  = rdata_r.key;
                  out_rt_nxt   = '0;
                  out_last_nxt = 1'b0;
                  if (drop) valid_nxt[p_idx_r] = 1'b0;
                end
              end
            endcase
          end
        end
        if (rd_cnt_r == CNT_W'(ENTRIES) && !p_vld_r) state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          out_key_nxt  = key_r;
          out_rt_nxt   = '0;
          case (mode_r)
            MODE_SEND: begin
              if (found_r || free_found_r) begin
                wr_en      = 1'b1;
                wr_addr    = send_slot;
                wr_data    = '{key: key_r, sent_time: now_r, retries: 8'd0};
                valid_nxt[send_slot] = 1'b1;
                out_ev_nxt = EV_RECORDED;
              end else begin
                out_ev_nxt = EV_TABLE_FULL;
              end
            end
            MODE_ACK: begin
              if (found_r) begin
                if (trip_r < min_r) min_nxt = trip_r;
                if (trip_r > max_r) max_nxt = trip_r;
                avg_nxt    = avg_sum[32:1];
                valid_nxt[slot_r] = 1'b0;
                out_ev_nxt = EV_ACK_MATCH;
                out_rt_nxt = trip_r;
              end else begin
                out_ev_nxt = EV_ACK_NOMATCH;
              end
            end
            default: begin
              out_ev_nxt  = EV_SCAN_DONE;
              out_key_nxt = '0;
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      p_vld_r   <= 1'b0;
      valid_r   <= '0;
      min_r     <= MIN_TRIP_RST;
      avg_r     <= AVG_TRIP_RST;
      max_r     <= MAX_TRIP_RST;
      limit_r   <= RETRY_LIMIT_RST;
      timeout_r <= RESEND_TIMEOUT_RST;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      valid_r   <= valid_nxt;
      min_r     <= min_nxt;
      avg_r     <= avg_nxt;
      max_r     <= max_nxt;
      limit_r   <= limit_nxt;
      timeout_r <= timeout_nxt;
      out_vld_r <= out_vld_nxt;
    end
    mode_r       <= mode_nxt;
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    p_idx_r      <= p_idx_nxt;
    found_r      <= found_nxt;
    slot_r       <= slot_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    trip_r       <= trip_nxt;
    out_ev_r     <= out_ev_nxt;
    out_key_r    <= out_key_nxt;
    out_rt_r     <= out_rt_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  // scan write-back targets the entry behind the one being read
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("table read and write hit the same entry");

  a_done_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ev_r == EV_SCAN_DONE) |-> (out_key_r == '0 && out_last_r))
    else $error("scan done word carries a key or lacks last");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (max_r != '0) |-> (min_r <= max_r))
    else $error("round trip minimum above maximum");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_free && mode_r == MODE_ACK && found_r)
      |=> !valid_r[$past(slot_r)])
    else $error("matched ack left its entry valid");

  a_scan_word_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && out_vld_nxt && !out_vld_r) |-> !out_last_nxt)
    else $error("resend word marked last");
`endif

endmodule
